// ----- rtl/core/led_breathing_sequencer_macros.svh -----
// Assertion macros shared by the LED breathing sequencer RTL.
`ifndef LED_BREATHING_SEQUENCER_MACROS_SVH
`define LED_BREATHING_SEQUENCER_MACROS_SVH

// Property checked on every clock edge outside reset.
`define LBS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked on every clock edge outside reset.
`define LBS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/core/lbs_pkg.sv -----
// Types and constants for the LED breathing sequencer.
package lbs_pkg;

  localparam int TICK_W  = 20;
  localparam int LEVEL_W = 10;
  localparam int LED_W   = 4;
  localparam int IDX_W   = 3;
  localparam int LEN_W   = 4;
  localparam int SEQ_W   = 32;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_STEP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_MAX         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LED_SEQUENCE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEQUENCE_LENGTH = 2'd3;

  // Reset values of the configuration registers
  localparam logic [TICK_W-1:0]  TICKS_PER_STEP_RST  = 20'd1960;
  localparam logic [LEVEL_W-1:0] PWM_MAX_RST         = 10'd255;
  localparam logic [SEQ_W-1:0]   LED_SEQUENCE_RST    = 32'd0;
  localparam logic [LEN_W-1:0]   SEQUENCE_LENGTH_RST = 4'd1;

  // Ramp settings handed to the ramp unit
  typedef struct packed {
    logic [TICK_W-1:0]  ticks_per_step;
    logic [LEVEL_W-1:0] pwm_max;
    logic [LEN_W-1:0]   sequence_length;
  } ramp_cfg_t;

  // Ramp state as it stands after the current tick
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [IDX_W-1:0]   table_index;
  } ramp_view_t;

  // Result item, first field in the highest bits
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [LED_W-1:0]   active_led;
    logic [LEVEL_W-1:0] led_level;
  } result_t;

endpackage

// ----- rtl/core/led_breathing_sequencer.sv -----
// Top level of the LED breathing sequencer.
//
// Usage: each transaction on the s_ channel is one timebase tick carrying the
// number of an LED to report. The block counts ticks; every ticks_per_step
// ticks the brightness ramp takes one step up to pwm_max and back down, and
// at the floor moves to the next LED of the packed led_sequence table.
// Every tick yields one transaction on the m_ channel: the queried LED's
// level (zero unless it is the active LED), the active LED and the level,
// all as they stand after that tick.
// The result is registered in the output buffer; one tick is taken per cycle
// while s_tready is high, set by the single register stage holding ramp state and result.
// A two-entry output buffer (result register plus skid register) lets one
// more tick enter while a result waits; s_tready falls only when both hold.
// Reset (rst, synchronous) clears the ramp and prescaler, loads the register
// defaults and empties the output buffer. Configuration is written through
// cfg_we/cfg_index/cfg_data; the user must do so only while no tick is in flight, the block does not enforce it.
`include "led_breathing_sequencer_macros.svh"

module led_breathing_sequencer
  import lbs_pkg::*;
#(
  parameter int SEQ_DEPTH = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  // Configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // Tick input
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [3:0] query_led, [7:4] zero
  // Result output
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [23:0]          m_tdata    // [9:0] led_level, [13:10] active_led, [23:14] level
);

  ramp_cfg_t           cfg;
  logic [SEQ_W-1:0]    led_sequence;
  ramp_view_t          view_next;
  result_t             result;
  result_t             out_data;
  result_t             skid_data;
  logic                out_valid;
  logic                skid_valid;
  logic                accept;
  logic                take;
  logic [LED_W-1:0]    active;
  logic [LED_W-1:0]    query_led;

  assign query_led  = s_tdata[LED_W-1:0];
  assign s_tready   = !skid_valid;
  assign accept     = s_tvalid && s_tready;
  assign take       = out_valid && m_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ticks_per_step  <= TICKS_PER_STEP_RST;
      cfg.pwm_max         <= PWM_MAX_RST;
      led_sequence        <= LED_SEQUENCE_RST;
      cfg.sequence_length <= SEQUENCE_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TICKS_PER_STEP:  cfg.ticks_per_step  <= cfg_data[TICK_W-1:0];
        REG_PWM_MAX:         cfg.pwm_max         <= cfg_data[LEVEL_W-1:0];
        REG_LED_SEQUENCE:    led_sequence        <= cfg_data[SEQ_W-1:0];
        REG_SEQUENCE_LENGTH: cfg.sequence_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  lbs_ramp #(
    .SEQ_DEPTH(SEQ_DEPTH)
  ) u_ramp (
    .clk       (clk),
    .rst       (rst),
    .tick      (accept),
    .cfg       (cfg),
    .view_next (view_next)
  );

  // Result of this tick from the updated ramp state
  assign active            = led_sequence[view_next.table_index * LED_W +: LED_W];
  assign result.level      = view_next.level;
  assign result.active_led = active;
  assign result.led_level  = (active == query_led) ? view_next.level : '0;

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= result;
      end
    end else if (accept) begin
      if (out_valid) begin
        skid_data <= result;
      end else begin
        out_data <= result;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // Checks
  `LBS_ASSERT_IMPL(a_skid_behind_out, skid_valid, m_tvalid, "skid entry without a result ahead of it")
  `LBS_ASSERT_IMPL(a_skid_on_stall, $rose(skid_valid), $past(m_tvalid && !m_tready), "skid loaded without a stall")
  `LBS_ASSERT_IMPL(a_led_level_match, m_tvalid && m_tdata[9:0] != '0, m_tdata[9:0] == m_tdata[23:14], "reported LED level differs from ramp level")

endmodule

// ----- rtl/core/lbs_ramp.sv -----
// Prescaler and brightness ramp with LED table index.
`include "led_breathing_sequencer_macros.svh"

module lbs_ramp
  import lbs_pkg::*;
#(
  parameter int SEQ_DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       tick,
  input  ramp_cfg_t  cfg,
  output ramp_view_t view_next
);

  logic [TICK_W-1:0]  tick_count;
  logic [TICK_W-1:0]  tick_count_next;
  logic [LEVEL_W-1:0] brightness;
  logic [LEVEL_W-1:0] brightness_next;
  logic               rising;
  logic               rising_next;
  logic [IDX_W-1:0]   table_index;
  logic [IDX_W-1:0]   table_index_next;

  logic [TICK_W:0]    count_inc;
  logic [LEN_W-1:0]   index_inc;
  logic               step;
  logic               turned;

  // Prescaler: a zero period behaves like one
  assign count_inc = {1'b0, tick_count} + {{TICK_W{1'b0}}, 1'b1};
  assign step      = count_inc >= {1'b0, cfg.ticks_per_step};
  assign index_inc = {1'b0, table_index} + {{(LEN_W-1){1'b0}}, 1'b1};

  // One ramp step: climb, turn at the peak, fall, advance at zero
  always_comb begin
    tick_count_next  = tick_count;
    brightness_next  = brightness;
    rising_next      = rising;
    table_index_next = table_index;
    turned           = 1'b0;
    if (tick) begin
      if (step) begin
        tick_count_next = '0;
        if (rising) begin
          if (brightness >= cfg.pwm_max) begin
            turned = 1'b1;
          end else begin
            brightness_next = brightness + {{(LEVEL_W-1){1'b0}}, 1'b1};
          end
        end
        if (!rising || turned) begin
          if (brightness == '0) begin
            rising_next = 1'b1;
            if (index_inc >= cfg.sequence_length || index_inc >= LEN_W'(SEQ_DEPTH)) begin
              table_index_next = '0;
            end else begin
              table_index_next = index_inc[IDX_W-1:0];
            end
          end else begin
            rising_next     = 1'b0;
            brightness_next = brightness - {{(LEVEL_W-1){1'b0}}, 1'b1};
          end
        end
      end else begin
        tick_count_next = count_inc[TICK_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= '0;
      brightness  <= '0;
      rising      <= 1'b1;
      table_index <= '0;
    end else begin
      tick_count  <= tick_count_next;
      brightness  <= brightness_next;
      rising      <= rising_next;
      table_index <= table_index_next;
    end
  end

  assign view_next.level       = brightness_next;
  assign view_next.table_index = table_index_next;

  // Checks
  `LBS_ASSERT(a_idle_holds, !tick |=> $stable(tick_count) && $stable(brightness) && $stable(rising) && $stable(table_index), "ramp state moved without a tick")
  `LBS_ASSERT_IMPL(a_level_on_step, brightness != $past(brightness), tick_count == '0, "level changed off a step")
  `LBS_ASSERT_IMPL(a_index_at_floor, table_index != $past(table_index), rising && brightness == '0, "index advanced away from the floor")

endmodule

// ----- dv/led_breathing_sequencer_tb.sv -----
// Testbench for the LED breathing sequencer: ticks streamed in, results checked against a ramp predictor.
module led_breathing_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lbs_pkg::*;

  localparam int TABLE_DEPTH = 8;
  localparam int PRINT_CAP   = 200;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_TICKS_PER_STEP;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = '0;    // [3:0] query_led, [7:4] zero
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [23:0]          m_tdata;         // [9:0] led_level, [13:10] active_led, [23:14] level

  // Traffic shaping, percent of cycles each side sits idle
  int send_idle_pct = 29;
  int recv_idle_pct = 87;

  // Ticks waiting to be driven, and levels expected back
  logic [LED_W-1:0] tick_queue[$];
  result_t          level_reports_q[$];
  int               mismatches = 0;
  result_t          seen, wanted;

  // Predictor copy of the registers
  logic [TICK_W-1:0]  p_tps   = TICKS_PER_STEP_RST;
  logic [LEVEL_W-1:0] p_peak  = PWM_MAX_RST;
  logic [SEQ_W-1:0]   p_table = LED_SEQUENCE_RST;
  logic [LEN_W-1:0]   p_len   = SEQUENCE_LENGTH_RST;

  // Predictor copy of the ramp state
  logic [TICK_W-1:0]  tick_cnt = '0;
  logic [LEVEL_W-1:0] bright   = '0;
  logic               going_up = 1'b1;
  logic [IDX_W-1:0]   seq_idx  = '0;

  led_breathing_sequencer DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Advance the ramp by one tick and return what the block should report
  function automatic result_t predict_tick(input logic [LED_W-1:0] query);
    logic [TICK_W:0] next_cnt;
    logic [LEN_W:0]  next_idx;
    result_t         res;
    next_cnt = tick_cnt + 1'b1;
    if (next_cnt >= p_tps) begin
      tick_cnt = '0;
      // turn at the peak; >= so a lowered peak still turns the ramp
      if (going_up) begin
        if (bright >= p_peak) going_up = 1'b0;
        else bright = bright + 1'b1;
      end
      // at the floor move to the next LED, wrapping on length or depth
      if (!going_up) begin
        if (bright == '0) begin
          next_idx = seq_idx + 1'b1;
          if (next_idx >= p_len || next_idx >= TABLE_DEPTH) next_idx = '0;
          seq_idx  = next_idx[IDX_W-1:0];
          going_up = 1'b1;
        end else begin
          bright = bright - 1'b1;
        end
      end
    end else begin
      tick_cnt = next_cnt[TICK_W-1:0];
    end
    res.level      = bright;
    res.active_led = p_table[seq_idx*LED_W +: LED_W];
    res.led_level  = (res.active_led == query) ? bright : '0;
    return res;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("%0t ns mismatch: %s", $realtime, what);
  endtask

  // One register write; the predictor takes the same masked value
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_TICKS_PER_STEP:  p_tps   = value[TICK_W-1:0];
      REG_PWM_MAX:         p_peak  = value[LEVEL_W-1:0];
      REG_LED_SEQUENCE:    p_table = value[SEQ_W-1:0];
      REG_SEQUENCE_LENGTH: p_len   = value[LEN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Program all four registers; bits above each register's width are don't-care
  task automatic set_ramp(input logic [TICK_W-1:0] tps, input logic [LEVEL_W-1:0] peak,
                          input logic [SEQ_W-1:0] table_bits, input logic [LEN_W-1:0] len);
    logic [CFG_W-1:0] junk;
    junk = $urandom_range(1) ? $urandom : '0;
    write_reg(REG_TICKS_PER_STEP, (junk << TICK_W) | tps);
    write_reg(REG_PWM_MAX, (junk << LEVEL_W) | peak);
    write_reg(REG_LED_SEQUENCE, table_bits);
    write_reg(REG_SEQUENCE_LENGTH, (junk << LEN_W) | len);
  endtask

  // Idle means nothing queued, nothing on the wire, nothing owed back
  task automatic wait_drained();
    do @(negedge clk);
    while (tick_queue.size() != 0 || s_tvalid || level_reports_q.size() != 0);
  endtask

  // Queue ticks, half of them asking for an LED that sits in the table
  task automatic run_ticks(input int count);
    @(negedge clk);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(1))
        tick_queue.push_back(p_table[$urandom_range(TABLE_DEPTH-1)*LED_W +: LED_W]);
      else
        tick_queue.push_back(LED_W'($urandom_range(15)));
    end
    wait_drained();
  endtask

  // Tick driver: predicts on each accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        level_reports_q.push_back(predict_tick(s_tdata[LED_W-1:0]));
      if (!s_tvalid || s_tready) begin
        if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= 8'(tick_queue.pop_front());
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random backpressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (m_tvalid && m_tready) begin
        seen = m_tdata;
        if (level_reports_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result %h", m_tdata));
        end else begin
          wanted = level_reports_q.pop_front();
          if (seen !== wanted)
            flag_mismatch($sformatf(
              "led_level %0d exp %0d, active_led %0d exp %0d, level %0d exp %0d",
              seen.led_level, wanted.led_level, seen.active_led, wanted.active_led,
              seen.level, wanted.level));
        end
      end
    end
  end

  // Stimulus sequence
  initial begin
    int                 sent;
    int                 count;
    logic [TICK_W-1:0]  tps;
    logic [LEVEL_W-1:0] peak;
    logic [SEQ_W-1:0]   table_bits;
    logic [LEN_W-1:0]   len;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset defaults, both query extremes
    @(negedge clk);
    tick_queue.push_back(4'h0);
    tick_queue.push_back(4'hF);
    wait_drained();

    // zero step period: one step per tick, short table
    write_reg(REG_TICKS_PER_STEP, '0);
    write_reg(REG_PWM_MAX, 32'd2);
    write_reg(REG_LED_SEQUENCE, 32'h7654_3F10);
    write_reg(REG_SEQUENCE_LENGTH, 32'd3);
    run_ticks(3);
    // zero peak: every step turns and advances
    write_reg(REG_PWM_MAX, '0);
    run_ticks(2);
    // zero length pins the index
    write_reg(REG_SEQUENCE_LENGTH, '0);
    run_ticks(2);
    // length past the table depth wraps at the depth
    write_reg(REG_SEQUENCE_LENGTH, 32'd15);
    run_ticks(10);
    // length cut below the current index
    write_reg(REG_SEQUENCE_LENGTH, 32'd2);
    run_ticks(2);
    // peak lowered under the level while climbing
    write_reg(REG_PWM_MAX, 32'd6);
    run_ticks(4);
    write_reg(REG_PWM_MAX, 32'd2);
    run_ticks(3);

    // random settings, traffic shape changes by thirds
    sent = 0;
    while (sent < 360) begin
      if (sent < 120) begin
        send_idle_pct = 29;
        recv_idle_pct = 87;
      end else if (sent < 240) begin
        send_idle_pct = 87;
        recv_idle_pct = 29;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case ($urandom_range(9))
        0:       tps = '0;
        1:       tps = '1;
        2, 3, 4: tps = TICK_W'($urandom_range(1, 2));
        default: tps = TICK_W'($urandom_range(1, 6));
      endcase
      case ($urandom_range(9))
        0:       peak = '0;
        1:       peak = '1;
        2:       peak = 10'd1;
        default: peak = LEVEL_W'($urandom_range(2, 12));
      endcase
      case ($urandom_range(9))
        0:       table_bits = '1;
        1:       table_bits = '0;
        default: table_bits = $urandom;
      endcase
      case ($urandom_range(9))
        0:       len = '0;
        1:       len = LEN_W'($urandom_range(9, 15));
        2:       len = LEN_W'(TABLE_DEPTH);
        default: len = LEN_W'($urandom_range(1, 8));
      endcase
      set_ramp(tps, peak, table_bits, len);
      count = $urandom_range(15, 60);
      run_ticks(count);
      sent += count;
    end

    // climb to the top level and turn there
    set_ramp(20'd1, '1, $urandom, LEN_W'(TABLE_DEPTH));
    if (going_up) count = 1023 - int'(bright) + 3;
    else count = int'(bright) + 1026;
    run_ticks(count);

    repeat (4) @(posedge clk);
    if (mismatches == 0 && level_reports_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
